>>> design/ppi2x_pkg.sv
// Shared constants and the coefficient table builder for the 2x polyphase interpolator.
// No dependencies; the top level imports this package.
package ppi2x_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int SAMPLE_MAX   = 32767;
   localparam int SAMPLE_MIN   = -32768;
   localparam int FRAC_BITS    = 40;
   localparam int BETA_SQ      = 81;
   localparam int TAP_DROP     = 14;
   localparam int SERIES_TERMS = 60;
   localparam int MAX_PROTO    = 128;
   localparam int COEF_SLOT    = 32;

   // Unsigned quotient by shift and subtract; only evaluated while the table is built.
   function automatic longint unsigned ppi2x_udiv(input longint unsigned num,
                                                  input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              i;
      begin
         quo = 0;
         rem = 0;
         for (i = 63; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den) begin
               rem = rem - den;
               quo = quo | (64'd1 << i);
            end
         end
         return quo;
      end
   endfunction

   // Scales one prototype tap to unity phase gain, rounds half away from zero
   // and saturates to the signed coefficient range.
   function automatic longint ppi2x_quant(input longint tap, input longint s_acc,
                                          input int cwidth);
      longint unsigned smag;
      longint unsigned sden;
      longint unsigned half;
      longint unsigned qq;
      longint unsigned lim;
      longint          v;
      begin
         smag = (tap < 0) ? longint'(-tap) : longint'(tap);
         sden = s_acc;
         half = sden >> 1;
         qq   = ppi2x_udiv((smag << (cwidth - 1)) + half, sden);
         lim  = 64'd1 << (cwidth - 1);
         if (tap < 0) begin
            v = (qq > lim) ? -longint'(lim) : -longint'(qq);
         end else begin
            v = (qq > lim - 64'd1) ? longint'(lim - 64'd1) : longint'(qq);
         end
         return v;
      end
   endfunction

   // Builds the whole coefficient table at elaboration time, one COEF_SLOT-bit slot
   // per coefficient: phase 0 taps first, then phase 1 taps.
   // The prototype is a Kaiser-windowed sinc; I0 is summed as a fixed-point power
   // series, and each phase is scaled to unity DC gain before rounding.
   function automatic logic [MAX_PROTO*COEF_SLOT-1:0] ppi2x_coef_table(input int taps,
                                                                       input int cwidth);
      longint unsigned dd;
      longint unsigned au;
      longint unsigned nn;
      longint unsigned den;
      longint unsigned yy;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned kk;
      longint unsigned mag;
      longint unsigned res;
      logic [127:0]    prod;
      logic [MAX_PROTO*COEF_SLOT-1:0] tbl;
      longint          proto [MAX_PROTO];
      longint          s0;
      longint          s1;
      longint          v;
      int              m;
      int              k;
      int              j;
      begin
         dd = longint'(2 * taps - 1);
         for (m = 0; m < 2 * taps; m++) begin
            if (longint'(2 * m) < longint'(dd)) begin
               au = dd - longint'(2 * m);
            end else begin
               au = longint'(2 * m) - dd;
            end
            nn   = dd * dd - au * au;
            den  = 64'd4 * dd * dd;
            yy   = ppi2x_udiv((longint'(BETA_SQ) * nn) << FRAC_BITS, den);
            sum  = 64'd1 << FRAC_BITS;
            term = sum;
            // Once a term truncates to zero every later term stays zero.
            for (k = 1; k < SERIES_TERMS; k++) begin
               prod = {64'd0, term} * {64'd0, yy};
               term = prod[FRAC_BITS +: 64];
               kk   = longint'(k * k);
               term = ppi2x_udiv(term, kk);
               sum  = sum + term;
            end
            mag = ppi2x_udiv(sum >> TAP_DROP, au);
            res = au & 64'd7;
            if (res == 64'd1 || res == 64'd3) begin
               proto[m] = longint'(mag);
            end else begin
               proto[m] = -longint'(mag);
            end
         end
         s0 = 0;
         s1 = 0;
         for (j = 0; j < taps; j++) begin
            s0 = s0 + proto[2 * j];
            s1 = s1 + proto[2 * j + 1];
         end
         if (s0 <= 0) begin
            s0 = 1;
         end
         if (s1 <= 0) begin
            s1 = 1;
         end
         tbl = '0;
         for (j = 0; j < taps; j++) begin
            v = ppi2x_quant(proto[2 * j], s0, cwidth);
            tbl[j * COEF_SLOT +: COEF_SLOT] = v[COEF_SLOT-1:0];
            v = ppi2x_quant(proto[2 * j + 1], s1, cwidth);
            tbl[(taps + j) * COEF_SLOT +: COEF_SLOT] = v[COEF_SLOT-1:0];
         end
         return tbl;
      end
   endfunction

endpackage

>>> design/polyphase_2x_interpolator.sv
// Two-times polyphase FIR interpolator: one sample in, phase-0 and phase-1 out.
// Depends on ppi2x_pkg for sample constants and the coefficient builder.
//
//  Channel  Ports       Direction  Payload
//  req      req_t*      in         tdata[15:0] sample_in (signed Q1.15)
//  rsp      rsp_t*      out        tdata[15:0] sample_out (signed Q1.15), tlast second_phase
//
// An item first has its sample taken into the history memory, then gets one
// history read and one multiply-accumulate per tap per phase through a single
// shared multiplier. Each phase result passes the read and product registers
// before it is loaded into the output register. Reset is immediate: per-entry
// valid bits make unwritten history read as zero. If a result finds the output
// register still full, the read and multiply pipeline halts until that transfer completes.
module polyphase_2x_interpolator #(
   parameter int PHASE_TAPS = 16,
   parameter int COEF_WIDTH = 18
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ppi2x_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ppi2x_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [15:0] sample_out
   output logic                            rsp_tlast    // second_phase
);

   import ppi2x_pkg::*;

   localparam int TW        = $clog2(PHASE_TAPS);
   localparam int ROM_DEPTH = 2 * PHASE_TAPS;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int PROD_W    = SAMPLE_W + COEF_WIDTH;
   localparam int ACC_W     = PROD_W + TW;
   localparam logic [TW-1:0] LAST_TAP = TW'(PHASE_TAPS - 1);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_WIDTH - 2);
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(SAMPLE_MIN);
   localparam logic [MAX_PROTO*COEF_SLOT-1:0] COEF_IMAGE =
      ppi2x_coef_table(PHASE_TAPS, COEF_WIDTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic first;
      logic last;
      logic phase;
   } tag_type;

   state_type                   state_ff, state_in;
   logic [TW-1:0]               tap_cnt_ff, tap_cnt_in;
   logic                        phase_ff, phase_in;
   logic [TW-1:0]               newest_ff, newest_in;
   logic [PHASE_TAPS-1:0]       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0]  hist_mem [PHASE_TAPS];
   logic signed [COEF_WIDTH-1:0] coef_rom [ROM_DEPTH];

   logic                        accept;
   logic                        issue;
   logic                        adv;
   logic                        load_out;
   logic [TW:0]                 wrap_addr;
   logic [TW-1:0]               rd_addr;
   logic [ROM_AW-1:0]           rom_idx;
   tag_type                     iss_tag;

   logic                        s1_vld_ff;
   tag_type                     s1_tag_ff;
   logic signed [SAMPLE_W-1:0]  rd_data_ff;
   logic                        rd_ok_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff;

   logic                        mul_vld_ff;
   tag_type                     mul_tag_ff;
   logic signed [SAMPLE_W-1:0]  tap_sample;
   logic signed [PROD_W-1:0]    prod_in, prod_ff;

   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     total;
   logic signed [ACC_W-1:0]     rounded;
   logic signed [ACC_W-1:0]     shifted;
   logic [SAMPLE_W-1:0]         sat_sample;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff;
   logic [SAMPLE_W-1:0]         rsp_data_ff;

   // Coefficient table, phase 0 in the lower half and phase 1 in the upper half.
   for (genvar ri = 0; ri < ROM_DEPTH; ri++) begin : g_coef
      assign coef_rom[ri] = COEF_IMAGE[ri * COEF_SLOT +: COEF_WIDTH];
   end

   // A phase result that cannot enter a full output register halts the pipeline.
   assign adv    = !(mul_vld_ff && mul_tag_ff.last && rsp_valid_ff && !rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign issue  = (state_ff == S_RUN) && adv;

   // Tap j sits j entries behind the newest sample in the circular history.
   assign wrap_addr = {1'b0, newest_ff} + (TW + 1)'(PHASE_TAPS) - {1'b0, tap_cnt_ff};
   assign rd_addr   = (newest_ff >= tap_cnt_ff) ? (newest_ff - tap_cnt_ff) : wrap_addr[TW-1:0];
   assign rom_idx   = phase_ff ? (ROM_AW'(PHASE_TAPS) + ROM_AW'(tap_cnt_ff))
                               : ROM_AW'(tap_cnt_ff);

   assign iss_tag.first = (tap_cnt_ff == '0);
   assign iss_tag.last  = (tap_cnt_ff == LAST_TAP);
   assign iss_tag.phase = phase_ff;

   always_comb begin
      state_in   = state_ff;
      tap_cnt_in = tap_cnt_ff;
      phase_in   = phase_ff;
      newest_in  = newest_ff;
      valid_in   = valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               newest_in           = (newest_ff == LAST_TAP) ? '0 : newest_ff + 1'b1;
               valid_in[newest_in] = 1'b1;
               tap_cnt_in          = '0;
               phase_in            = 1'b0;
               state_in            = S_RUN;
            end
         end
         S_RUN: begin
            if (adv) begin
               if (tap_cnt_ff == LAST_TAP) begin
                  tap_cnt_in = '0;
                  phase_in   = !phase_ff;
                  if (phase_ff) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  tap_cnt_in = tap_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tap_cnt_ff <= '0;
         phase_ff   <= 1'b0;
         newest_ff  <= '0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         tap_cnt_ff <= tap_cnt_in;
         phase_ff   <= phase_in;
         newest_ff  <= newest_in;
         valid_ff   <= valid_in;
      end
   end

   // History memory: one write port for the incoming sample, one registered read port.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[newest_in] <= req_tdata;
      end
      if (adv) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_ok_ff   <= valid_ff[rd_addr];
         coef_ff    <= coef_rom[rom_idx];
         s1_tag_ff  <= iss_tag;
      end
   end

   assign tap_sample = rd_ok_ff ? rd_data_ff : '0;
   assign prod_in    = tap_sample * coef_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         mul_tag_ff <= s1_tag_ff;
      end
   end

   // The last product of a phase bypasses the accumulator straight into rounding.
   assign total   = acc_ff + ACC_W'(prod_ff);
   assign rounded = total + RND_HALF;
   assign shifted = rounded >>> (COEF_WIDTH - 1);

   always_comb begin
      if (shifted > SAT_HI) begin
         sat_sample = SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         sat_sample = SAMPLE_W'(SAT_LO);
      end else begin
         sat_sample = shifted[SAMPLE_W-1:0];
      end
   end

   assign load_out = mul_vld_ff && mul_tag_ff.last && adv;

   always_comb begin
      acc_in = acc_ff;
      if (mul_vld_ff && adv) begin
         acc_in = mul_tag_ff.last ? '0 : total;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_vld_ff  <= issue;
            mul_vld_ff <= s1_vld_ff;
         end
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= sat_sample;
         rsp_last_ff <= mul_tag_ff.phase;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Every accepted sample starts its dot product at tap zero of phase zero.
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RUN) && (tap_cnt_ff == '0) && !phase_ff)
      else $error("sequencer did not restart at phase 0, tap 0");

   // The accumulator must be empty when the first product of a phase arrives.
   a_acc_empty: assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && mul_tag_ff.first) |-> (acc_ff == '0))
      else $error("accumulator holds stale sum at start of phase");

   // The pipeline halts only behind a full output register with a finished phase.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !adv |-> (rsp_valid_ff && !rsp_tready && mul_vld_ff && mul_tag_ff.last))
      else $error("pipeline halted without a blocked result");

endmodule
